FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_CLK(lbl, !(expr), msg)

`endif

FILE: hw/rtl/rnc_pkg.sv
// ----------------------------------------------------------------------------
// rnc_pkg
// Types, constants and helpers shared by the radix number converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rnc_pkg;

  localparam int unsigned MaxCharsDef  = 13;
  localparam int unsigned FracDigitsDef = 12;
  localparam int unsigned IntW  = 52;
  localparam int unsigned NumW  = 48;
  localparam int unsigned DenW  = 49;
  localparam int unsigned ProdW = 57;
  localparam int unsigned BaseW = 5;
  localparam int unsigned IdivSteps = IntW / 4;
  localparam int unsigned IcntW = $clog2(IntW + 1);

  localparam logic [7:0] ChDot  = 8'h2e;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChLa   = 8'h61;
  localparam logic [7:0] ChLf   = 8'h66;
  localparam logic [7:0] ChUa   = 8'h41;
  localparam logic [7:0] ChUz   = 8'h5a;

  typedef enum logic {
    REG_SOURCE_BASE = 1'b0,
    REG_TARGET_BASE = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_POST, S_CHECK, S_ERR, S_IDIV, S_FMUL, S_FDIV, S_IRD, S_IOUT, S_DOT, S_FOUT
  } state_e;

  typedef enum logic [2:0] {
    OSEL_NONE, OSEL_ERR, OSEL_INT, OSEL_DOT, OSEL_FRAC
  } osel_e;

  typedef struct packed {
    logic  absorb;
    logic  den_mul;
    logic  idiv_init;
    logic  idiv_step;
    logic  fmul;
    logic  fstep;
    logic  rd;
    logic  fo_next;
    logic  clear;
    osel_e osel;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic num_zero;
    logic idiv_done;
    logic fdig_end;
    logic frac_done;
    logic int_empty;
    logic nfrac_zero;
    logic fo_last;
  } status_t;

  function automatic logic base_ok(logic [BaseW-1:0] b);
    return (b >= BaseW'(2)) && (b <= BaseW'(16));
  endfunction

  function automatic logic [7:0] digit_char(logic [3:0] d);
    return (d <= 4'd9) ? (ChZero + {4'b0, d}) : (ChLa + {4'b0, d} - 8'd10);
  endfunction

endpackage

FILE: hw/rtl/rnc_dpath.sv
// ----------------------------------------------------------------------------
// rnc_dpath
// Value registers, shared multiplier, digit dividers and digit store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rnc_dpath #(
  parameter int unsigned MAX_CHARS   = rnc_pkg::MaxCharsDef,
  parameter int unsigned FRAC_DIGITS = rnc_pkg::FracDigitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [rnc_pkg::BaseW-1:0] cfg_data_i,
  input  logic [7:0]                in_char_i,
  input  logic                      in_last_i,
  input  rnc_pkg::cmd_t             cmd_i,
  output rnc_pkg::status_t          status_o,
  output logic [7:0]                out_char_o,
  output logic                      out_last_o,
  output logic                      out_bad_o
);

  localparam int unsigned FiW = (FRAC_DIGITS > 1) ? $clog2(FRAC_DIGITS) : 1;
  localparam int unsigned NfW = $clog2(FRAC_DIGITS + 1);
  localparam int unsigned IntW = rnc_pkg::IntW;
  localparam int unsigned NumW = rnc_pkg::NumW;
  localparam int unsigned DenW = rnc_pkg::DenW;
  localparam int unsigned ProdW = rnc_pkg::ProdW;
  localparam int unsigned BaseW = rnc_pkg::BaseW;
  localparam int unsigned IcntW = rnc_pkg::IcntW;

  logic [BaseW-1:0] sb_q, tb_q;
  logic [IntW-1:0]  iv_q, iv_d;
  logic [NumW-1:0]  num_q, num_d;
  logic [DenW-1:0]  den_q, den_d;
  logic [3:0]       cc_q, cc_d;
  logic             dot_q, dot_d, err_q, err_d, pend_q, pend_d;
  logic [IntW-1:0]  w_q, w_d;
  logic [4:0]       r_q, r_d;
  logic [3:0]       step_q, step_d;
  logic [ProdW-4:0] p_q, p_d;
  logic [1:0]       k_q, k_d;
  logic [3:0]       dig_q, dig_d;
  logic [FiW-1:0]   fi_q, fi_d, fo_q, fo_d;
  logic [NfW-1:0]   nfrac_q, nfrac_d;
  logic [IcntW-1:0] icnt_q, icnt_d;
  logic [3:0]       rdata_q;
  logic [3:0]       imem [IntW];
  logic [3:0]       frac_q [FRAC_DIGITS];

  logic [IntW-1:0]  mul_a;
  logic [BaseW-1:0] mul_b;
  logic [ProdW-1:0] prod;
  logic [7:0]       c;
  logic             is_dot, is_num, is_alpha;
  logic [3:0]       d;
  logic [4:0]       rs;
  logic [5:0]       t;
  logic [3:0]       qb;
  logic [ProdW-4:0] dsh;
  logic             fqb;
  logic             idiv_final;

  always_comb begin
    mul_a = cmd_i.den_mul ? IntW'(den_q) :
            (cmd_i.fmul || dot_q) ? IntW'(num_q) : iv_q;
    mul_b = cmd_i.fmul ? tb_q : sb_q;
    prod  = {{(ProdW-IntW){1'b0}}, mul_a} * {{(ProdW-BaseW){1'b0}}, mul_b};
  end

  always_comb begin
    c = in_char_i;
    if (c >= rnc_pkg::ChUa && c <= rnc_pkg::ChUz) begin
      c = c + 8'd32;
    end
    is_dot   = (c == rnc_pkg::ChDot);
    is_num   = (c >= rnc_pkg::ChZero) && (c <= rnc_pkg::ChNine);
    is_alpha = (c >= rnc_pkg::ChLa) && (c <= rnc_pkg::ChLf);
    d = is_num ? 4'(c - rnc_pkg::ChZero) : 4'(c - rnc_pkg::ChLa + 8'd10);
  end

  always_comb begin
    rs = r_q;
    for (int j = 0; j < 4; j++) begin
      t = {rs, w_q[IntW-1-j]};
      if (t >= {1'b0, tb_q}) begin
        rs    = 5'(t - {1'b0, tb_q});
        qb[3-j] = 1'b1;
      end else begin
        rs    = t[4:0];
        qb[3-j] = 1'b0;
      end
    end
  end

  always_comb begin
    dsh = (ProdW-3)'({4'b0, den_q}) << k_q;
    fqb = (p_q >= dsh);
  end

  assign idiv_final = cmd_i.idiv_step && (step_q == 4'(rnc_pkg::IdivSteps - 1));

  always_comb begin
    iv_d = iv_q; num_d = num_q; den_d = den_q; cc_d = cc_q;
    dot_d = dot_q; err_d = err_q; pend_d = pend_q;
    w_d = w_q; r_d = r_q; step_d = step_q; p_d = p_q; k_d = k_q; dig_d = dig_q;
    fi_d = fi_q; fo_d = fo_q; nfrac_d = nfrac_q; icnt_d = icnt_q;
    if (cmd_i.absorb) begin
      if (cc_q < 4'd15) begin
        cc_d = cc_q + 4'd1;
      end
      if (!err_q) begin
        if (cc_d > 4'(MAX_CHARS) || !rnc_pkg::base_ok(sb_q)) begin
          err_d = 1'b1;
        end else if (is_dot) begin
          if (dot_q || cc_q == 4'd0 || in_last_i) begin
            err_d = 1'b1;
          end
          dot_d = 1'b1;
        end else if (!(is_num || is_alpha) || {1'b0, d} >= sb_q) begin
          err_d = 1'b1;
        end else if (dot_q) begin
          num_d  = prod[NumW-1:0] + NumW'(d);
          pend_d = 1'b1;
        end else begin
          iv_d = prod[IntW-1:0] + IntW'(d);
        end
      end
    end
    if (cmd_i.den_mul && pend_q) begin
      den_d  = prod[DenW-1:0];
      pend_d = 1'b0;
    end
    if (cmd_i.idiv_init) begin
      w_d = iv_q; r_d = '0; step_d = '0; icnt_d = '0;
      fi_d = '0; fo_d = '0; nfrac_d = '0;
    end
    if (cmd_i.idiv_step) begin
      w_d = {w_q[IntW-5:0], qb};
      if (idiv_final) begin
        r_d = '0; step_d = '0; icnt_d = icnt_q + IcntW'(1);
      end else begin
        r_d = rs; step_d = step_q + 4'd1;
      end
    end
    if (cmd_i.fmul) begin
      p_d = prod[ProdW-4:0]; k_d = 2'd3; dig_d = '0;
    end
    if (cmd_i.fstep) begin
      dig_d = {dig_q[2:0], fqb};
      k_d   = k_q - 2'd1;
      if (fqb) begin
        p_d = p_q - dsh;
      end
      if (k_q == 2'd0) begin
        num_d = p_d[NumW-1:0];
        if (dig_d != 4'd0) begin
          nfrac_d = NfW'(fi_q) + NfW'(1);
        end
        if (fi_q != FiW'(FRAC_DIGITS - 1)) begin
          fi_d = fi_q + FiW'(1);
        end
      end
    end
    if (cmd_i.rd) begin
      icnt_d = icnt_q - IcntW'(1);
    end
    if (cmd_i.fo_next) begin
      fo_d = fo_q + FiW'(1);
    end
    if (cmd_i.clear) begin
      iv_d = '0; num_d = '0; den_d = DenW'(1); cc_d = '0;
      dot_d = 1'b0; err_d = 1'b0; pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_q <= BaseW'(10); tb_q <= BaseW'(2);
      iv_q <= '0; num_q <= '0; den_q <= DenW'(1); cc_q <= '0;
      dot_q <= 1'b0; err_q <= 1'b0; pend_q <= 1'b0;
      step_q <= '0; k_q <= '0; fi_q <= '0; fo_q <= '0; nfrac_q <= '0; icnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (rnc_pkg::reg_idx_e'(cfg_idx_i))
          rnc_pkg::REG_SOURCE_BASE: sb_q <= cfg_data_i;
          rnc_pkg::REG_TARGET_BASE: tb_q <= cfg_data_i;
          default: ;
        endcase
      end
      iv_q <= iv_d; num_q <= num_d; den_q <= den_d; cc_q <= cc_d;
      dot_q <= dot_d; err_q <= err_d; pend_q <= pend_d;
      step_q <= step_d; k_q <= k_d; fi_q <= fi_d; fo_q <= fo_d;
      nfrac_q <= nfrac_d; icnt_q <= icnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d; r_q <= r_d; p_q <= p_d; dig_q <= dig_d;
    if (idiv_final) begin
      imem[icnt_q[IcntW-1:0]] <= rs[3:0];
    end
    if (cmd_i.rd) begin
      rdata_q <= imem[icnt_d];
    end
    if (cmd_i.fstep && k_q == 2'd0) begin
      frac_q[fi_q] <= dig_d;
    end
  end

  always_comb begin
    status_o.err        = err_q || !rnc_pkg::base_ok(tb_q);
    status_o.num_zero   = (num_q == '0);
    status_o.idiv_done  = idiv_final && (w_d == '0);
    status_o.fdig_end   = (k_q == 2'd0);
    status_o.frac_done  = (fi_q == FiW'(FRAC_DIGITS - 1));
    status_o.int_empty  = (icnt_q == '0);
    status_o.nfrac_zero = (nfrac_q == '0);
    status_o.fo_last    = ((NfW'(fo_q) + NfW'(1)) == nfrac_q);
  end

  always_comb begin
    out_char_o = 8'd0; out_last_o = 1'b0; out_bad_o = 1'b0;
    unique case (cmd_i.osel)
      rnc_pkg::OSEL_ERR: begin
        out_last_o = 1'b1; out_bad_o = 1'b1;
      end
      rnc_pkg::OSEL_INT: begin
        out_char_o = rnc_pkg::digit_char(rdata_q);
        out_last_o = status_o.int_empty && status_o.nfrac_zero;
      end
      rnc_pkg::OSEL_DOT: out_char_o = rnc_pkg::ChDot;
      rnc_pkg::OSEL_FRAC: begin
        out_char_o = rnc_pkg::digit_char(frac_q[fo_q]);
        out_last_o = status_o.fo_last;
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/rnc_ctrl.sv
// ----------------------------------------------------------------------------
// rnc_ctrl
// Sequencer for absorbing characters and emitting the converted text.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rnc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  rnc_pkg::status_t status_i,
  output rnc_pkg::cmd_t    cmd_o
);

  rnc_pkg::state_e state_q, state_d;
  logic            last_q, last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rnc_pkg::S_IDLE;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    cmd_o       = '0;
    cmd_o.osel  = rnc_pkg::OSEL_NONE;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      rnc_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.absorb = 1'b1;
          last_d  = in_last_i;
          state_d = rnc_pkg::S_POST;
        end
      end
      rnc_pkg::S_POST: begin
        cmd_o.den_mul = 1'b1;
        state_d = last_q ? rnc_pkg::S_CHECK : rnc_pkg::S_IDLE;
      end
      rnc_pkg::S_CHECK: begin
        if (status_i.err) begin
          state_d = rnc_pkg::S_ERR;
        end else begin
          cmd_o.idiv_init = 1'b1;
          state_d = rnc_pkg::S_IDIV;
        end
      end
      rnc_pkg::S_ERR: begin
        out_valid_o = 1'b1;
        cmd_o.osel  = rnc_pkg::OSEL_ERR;
        if (out_ready_i) begin
          cmd_o.clear = 1'b1;
          state_d = rnc_pkg::S_IDLE;
        end
      end
      rnc_pkg::S_IDIV: begin
        cmd_o.idiv_step = 1'b1;
        if (status_i.idiv_done) begin
          state_d = status_i.num_zero ? rnc_pkg::S_IRD : rnc_pkg::S_FMUL;
        end
      end
      rnc_pkg::S_FMUL: begin
        cmd_o.fmul = 1'b1;
        state_d = rnc_pkg::S_FDIV;
      end
      rnc_pkg::S_FDIV: begin
        cmd_o.fstep = 1'b1;
        if (status_i.fdig_end) begin
          state_d = status_i.frac_done ? rnc_pkg::S_IRD : rnc_pkg::S_FMUL;
        end
      end
      rnc_pkg::S_IRD: begin
        cmd_o.rd = 1'b1;
        state_d = rnc_pkg::S_IOUT;
      end
      rnc_pkg::S_IOUT: begin
        out_valid_o = 1'b1;
        cmd_o.osel  = rnc_pkg::OSEL_INT;
        if (out_ready_i) begin
          if (!status_i.int_empty) begin
            state_d = rnc_pkg::S_IRD;
          end else if (status_i.nfrac_zero) begin
            cmd_o.clear = 1'b1;
            state_d = rnc_pkg::S_IDLE;
          end else begin
            state_d = rnc_pkg::S_DOT;
          end
        end
      end
      rnc_pkg::S_DOT: begin
        out_valid_o = 1'b1;
        cmd_o.osel  = rnc_pkg::OSEL_DOT;
        if (out_ready_i) begin
          state_d = rnc_pkg::S_FOUT;
        end
      end
      rnc_pkg::S_FOUT: begin
        out_valid_o = 1'b1;
        cmd_o.osel  = rnc_pkg::OSEL_FRAC;
        if (out_ready_i) begin
          if (status_i.fo_last) begin
            cmd_o.clear = 1'b1;
            state_d = rnc_pkg::S_IDLE;
          end else begin
            cmd_o.fo_next = 1'b1;
          end
        end
      end
      default: state_d = rnc_pkg::S_IDLE;
    endcase
  end

  `ASSERT_NEVER(a_in_out_overlap, in_ready_o && out_valid_o, "input and output active together")
  `ASSERT_CLK(a_clear_idle, cmd_o.clear |=> state_q == rnc_pkg::S_IDLE, "clear not followed by idle")
  `ASSERT_CLK(a_idiv_exit, state_q == rnc_pkg::S_IDIV |=> (state_q == rnc_pkg::S_IDIV || state_q == rnc_pkg::S_IRD || state_q == rnc_pkg::S_FMUL), "bad exit from integer division")

endmodule

FILE: hw/rtl/radix_number_converter_core.sv
// ----------------------------------------------------------------------------
// radix_number_converter_core
// Converts a number text between radices, with fractional part.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         tdata = in_char, tlast = in_last
// m_axis    out        tdata = out_char, tlast = out_last, tuser = bad_input
// cfg       in         index 0 source base, index 1 target base
//
// Each character is absorbed first; for a fraction digit the shared multiplier then scales the denominator.
// On the last character each integer digit takes a full pass of the 4-bit-per-cycle divider over the 52-bit value,
// and each of the 12 fraction digits is a multiply followed by four subtract steps.
// Integer digits are read back from the digit memory one at a time, each read followed by its output beat.
// Reset is asynchronous and clears control state; no clearing pass is needed.
// Input is held off while results are being produced or stalled.
`timescale 1ns / 1ps

module radix_number_converter_core #(
  parameter int unsigned MAX_CHARS   = rnc_pkg::MaxCharsDef,
  parameter int unsigned FRAC_DIGITS = rnc_pkg::FracDigitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [rnc_pkg::BaseW-1:0] cfg_data_i,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [7:0]                s_axis_tdata_i,  // in_char
  input  logic                      s_axis_tlast_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [7:0]                m_axis_tdata_o,  // out_char
  output logic                      m_axis_tlast_o,
  output logic                      m_axis_tuser_o   // bad_input
);

  rnc_pkg::cmd_t    cmd;
  rnc_pkg::status_t status;

  rnc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_last_i   (s_axis_tlast_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rnc_dpath #(
    .MAX_CHARS   (MAX_CHARS),
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_char_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_char_o (m_axis_tdata_o),
    .out_last_o (m_axis_tlast_o),
    .out_bad_o  (m_axis_tuser_o)
  );

endmodule

FILE: dv/tb_radix_number_converter_core.sv
// ----------------------------------------------------------------------------
// tb_radix_number_converter_core
// Streams number texts into the converter under random sender bursts and
// receiver stalls, predicts every output beat and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_radix_number_converter_core;

  localparam int unsigned WdLimit = 3000;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       bad;
  } out_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [rnc_pkg::BaseW-1:0] cfg_data_i = '0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = '0;
  logic s_axis_tlast_i = 1'b0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;
  logic m_axis_tlast_o;
  logic m_axis_tuser_o;

  radix_number_converter_core u_top (.*);

  always #6 clk_i = ~clk_i;

  logic [4:0] src_base, tgt_base;
  logic [51:0] int_acc;
  logic [47:0] frac_num;
  logic [48:0] frac_den;
  logic [3:0] char_cnt;
  logic dot_seen, err_seen;
  out_beat_t expected_q[$];
  int fails = 0;
  int burst_left = 0;
  int hold_left = 0;
  int rx_mode = 0;
  int idle_cycles = 0;

  function automatic logic base_valid(logic [4:0] b);
    return b >= 5'd2 && b <= 5'd16;
  endfunction

  function automatic logic [7:0] to_digit(logic [63:0] d);
    return d <= 9 ? rnc_pkg::ChZero + d[7:0] : rnc_pkg::ChLa + d[7:0] - 8'd10;
  endfunction

  task automatic clear_text();
    int_acc = '0;
    frac_num = '0;
    frac_den = 49'd1;
    char_cnt = '0;
    dot_seen = 1'b0;
    err_seen = 1'b0;
  endtask

  task automatic push_beat(logic [7:0] ch, logic last, logic bad);
    out_beat_t b;
    b.ch = ch;
    b.last = last;
    b.bad = bad;
    expected_q.push_back(b);
  endtask

  task automatic absorb_char(logic [7:0] c_in, logic last);
    logic first;
    logic [7:0] c;
    logic [63:0] d, t;
    first = (char_cnt == 0);
    c = c_in;
    if (char_cnt < 15) char_cnt++;
    if (err_seen) return;
    if (char_cnt > rnc_pkg::MaxCharsDef || !base_valid(src_base)) begin
      err_seen = 1'b1;
      return;
    end
    if (c >= rnc_pkg::ChUa && c <= rnc_pkg::ChUz) c = c + 8'd32;
    if (c == rnc_pkg::ChDot) begin
      if (dot_seen || first || last) err_seen = 1'b1;
      dot_seen = 1'b1;
      return;
    end
    if (c >= rnc_pkg::ChZero && c <= rnc_pkg::ChNine) d = 64'(c - rnc_pkg::ChZero);
    else if (c >= rnc_pkg::ChLa && c <= rnc_pkg::ChLf) d = 64'(c - rnc_pkg::ChLa) + 64'd10;
    else begin
      err_seen = 1'b1;
      return;
    end
    if (d >= 64'(src_base)) begin
      err_seen = 1'b1;
      return;
    end
    if (dot_seen) begin
      t = 64'(frac_num) * 64'(src_base) + d;
      frac_num = t[47:0];
      t = 64'(frac_den) * 64'(src_base);
      frac_den = t[48:0];
    end else begin
      t = 64'(int_acc) * 64'(src_base) + d;
      int_acc = t[51:0];
    end
  endtask

  task automatic predict_text_end();
    logic [63:0] digs[64];
    logic [63:0] frac[12];
    logic [63:0] v, num, den;
    int nint, nfrac;
    nint = 0;
    nfrac = 0;
    if (err_seen || !base_valid(tgt_base) || frac_den == 0) begin
      push_beat(8'h00, 1'b1, 1'b1);
      return;
    end
    v = 64'(int_acc);
    if (v == 0) begin
      digs[nint] = '0;
      nint++;
    end
    while (v != 0 && nint < 64) begin
      digs[nint] = v % 64'(tgt_base);
      nint++;
      v = v / 64'(tgt_base);
    end
    num = 64'(frac_num);
    den = 64'(frac_den);
    if (num >= den) num = num % den;
    if (num != 0) begin
      for (int i = 0; i < rnc_pkg::FracDigitsDef; i++) begin
        num = num * 64'(tgt_base);
        frac[i] = num / den;
        num = num % den;
      end
      nfrac = rnc_pkg::FracDigitsDef;
      while (nfrac > 0 && frac[nfrac-1] == 0) nfrac--;
    end
    for (int i = nint - 1; i >= 0; i--) push_beat(to_digit(digs[i]), i == 0 && nfrac == 0, 1'b0);
    if (nfrac > 0) begin
      push_beat(rnc_pkg::ChDot, 1'b0, 1'b0);
      for (int i = 0; i < nfrac; i++) push_beat(to_digit(frac[i]), i == nfrac - 1, 1'b0);
    end
  endtask

  task automatic send_char(logic [7:0] c, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= c;
    s_axis_tlast_i <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    absorb_char(c, last);
    if (last) begin
      predict_text_end();
      clear_text();
    end
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(rnc_pkg::reg_idx_e idx, logic [4:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == rnc_pkg::REG_SOURCE_BASE) src_base = val;
    else tgt_base = val;
  endtask

  task automatic set_bases(logic [4:0] s, logic [4:0] t);
    drain();
    write_reg(rnc_pkg::REG_SOURCE_BASE, s);
    write_reg(rnc_pkg::REG_TARGET_BASE, t);
  endtask

  function automatic logic [7:0] rand_digit(logic [4:0] base);
    int d;
    d = $urandom_range(0, base - 1);
    if (d <= 9) return 8'(rnc_pkg::ChZero + d);
    return 8'(($urandom_range(0, 1) ? rnc_pkg::ChUa : rnc_pkg::ChLa) + d - 10);
  endfunction

  task automatic send_good_text();
    int len, dot_pos;
    len = $urandom_range(1, rnc_pkg::MaxCharsDef);
    dot_pos = (len >= 3 && $urandom_range(0, 1)) ? $urandom_range(1, len - 2) : -1;
    for (int i = 0; i < len; i++)
      send_char(i == dot_pos ? rnc_pkg::ChDot : rand_digit(src_base), i == len - 1);
  endtask

  task automatic send_noise_text();
    int len;
    len = $urandom_range(1, 16);
    for (int i = 0; i < len; i++) send_char(8'($urandom_range(0, 255)), i == len - 1);
  endtask

  task automatic test_defaults();
    send_text("0");
    send_text("13");
    send_text("9.75");
    send_text("12.5A");
    send_text("0.1");
    drain();
  endtask

  task automatic test_extreme_bases();
    set_bases(5'd16, 5'd16);
    send_text("fffffffffffff");
    send_text("FF.8");
    set_bases(5'd16, 5'd2);
    send_text("0.00000000001");
    send_text("a.b");
    set_bases(5'd2, 5'd16);
    send_text("1011.0110");
    set_bases(5'd10, 5'd10);
    send_text("1234567890123");
    drain();
  endtask

  task automatic test_errors();
    set_bases(5'd10, 5'd10);
    send_text(".5");
    send_text("5.");
    send_text("1..2");
    send_text("1.2.3");
    send_text("12a");
    send_text("z");
    send_text("12345678901234");
    send_text("1234567890123456");
    send_text(".");
    drain();
    set_bases(5'd1, 5'd10);
    send_text("1");
    set_bases(5'd0, 5'd10);
    send_text("1");
    set_bases(5'd31, 5'd10);
    send_text("1");
    set_bases(5'd10, 5'd17);
    send_text("1");
    set_bases(5'd10, 5'd1);
    send_text("1");
    set_bases(5'd10, 5'd31);
    send_text("1");
    drain();
  endtask

  task automatic test_random();
    int items;
    items = 0;
    while (items < 500) begin
      set_bases($urandom_range(0, 3) == 0 ? 5'($urandom_range(0, 31)) :
                5'($urandom_range(2, 16)),
                $urandom_range(0, 7) == 0 ? 5'($urandom_range(0, 31)) :
                5'($urandom_range(2, 16)));
      repeat (8) begin
        if ($urandom_range(0, 4) == 0) send_noise_text();
        else send_good_text();
        items += 7;
      end
      drain();
    end
  endtask

  task automatic test_backpressure();
    set_bases(5'd16, 5'd2);
    hold_left = 500;
    repeat (4) send_good_text();
    drain();
  endtask

  always @(posedge clk_i) begin
    out_beat_t exp_b;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected beat, actual char %h last %b bad %b", $time,
                 m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
        fails++;
      end else begin
        exp_b = expected_q.pop_front();
        if (exp_b.ch !== m_axis_tdata_o)
          $display("%0t: char mismatch, expected %h actual %h", $time, exp_b.ch, m_axis_tdata_o);
        if (exp_b.last !== m_axis_tlast_o)
          $display("%0t: last mismatch, expected %b actual %b", $time, exp_b.last,
                   m_axis_tlast_o);
        if (exp_b.bad !== m_axis_tuser_o)
          $display("%0t: bad_input mismatch, expected %b actual %b", $time, exp_b.bad,
                   m_axis_tuser_o);
        if (exp_b.ch !== m_axis_tdata_o || exp_b.last !== m_axis_tlast_o ||
            exp_b.bad !== m_axis_tuser_o)
          fails++;
      end
    end
    if ($urandom_range(0, 199) == 0) rx_mode = $urandom_range(0, 2);
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (rx_mode == 0) m_axis_tready_i <= 1'b1;
    else if (rx_mode == 1) m_axis_tready_i <= 1'($urandom_range(0, 1));
    else m_axis_tready_i <= $urandom_range(0, 4) != 0;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WdLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    src_base = 5'd10;
    tgt_base = 5'd2;
    clear_text();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_extreme_bases();
    test_errors();
    test_backpressure();
    test_random();
    if (fails == 0 && expected_q.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: radix_number_converter_core.f
+incdir+hw/rtl
hw/rtl/rnc_pkg.sv
hw/rtl/rnc_dpath.sv
hw/rtl/rnc_ctrl.sv
hw/rtl/radix_number_converter_core.sv
dv/tb_radix_number_converter_core.sv
